[design/answer_machine_detector_fsm_defines.svh]
// Assertion macros used by the answer machine detector FSM.
`ifndef ANSWER_MACHINE_DETECTOR_FSM_DEFINES_SVH
`define ANSWER_MACHINE_DETECTOR_FSM_DEFINES_SVH

`ifndef SYNTH
`define AMD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("answer machine detector: assertion failed");
`else
`define AMD_ASSERT(label, clk, rst_n, prop)
`endif

`ifndef SYNTH
`define AMD_ASSERT_NEXT(label, clk, rst_n, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("answer machine detector: assertion failed");
`else
`define AMD_ASSERT_NEXT(label, clk, rst_n, cause, effect)
`endif

`endif

[design/amd_pkg.sv]
package amd_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEAD_AIR_LIMIT      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MACHINE_VOICE_LIMIT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] DEAD_AIR_LIMIT_RESET      = 16'd200;
    localparam logic [CFG_DATA_W-1:0] MACHINE_VOICE_LIMIT_RESET = 16'd90;

    localparam logic [1:0] VAD_SILENCE_BEGIN = 2'd0;
    localparam logic [1:0] VAD_SILENCE       = 2'd1;
    localparam logic [1:0] VAD_VOICE_BEGIN   = 2'd2;
    localparam logic [1:0] VAD_VOICE         = 2'd3;

    localparam logic [2:0] EV_DEAD_AIR        = 3'd0;
    localparam logic [2:0] EV_HUMAN_SILENCE   = 3'd1;
    localparam logic [2:0] EV_HUMAN_VOICE     = 3'd2;
    localparam logic [2:0] EV_MACHINE_SILENCE = 3'd3;
    localparam logic [2:0] EV_MACHINE_VOICE   = 3'd4;

    typedef enum logic [4:0] {
        PH_WAIT    = 5'b00001,
        PH_DETECT  = 5'b00010,
        PH_HUMAN   = 5'b00100,
        PH_MACHINE = 5'b01000,
        PH_DONE    = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] sample_position;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  detect_event;
        logic [31:0] event_sample;
    } out_item_t;

endpackage

[design/answer_machine_detector_fsm.sv]
// Answering-machine detector. Each input transfer is one voice-activity event for one
// audio slice; it reports dead air, a human or a machine, and after a human or machine
// verdict reports every silence-begin or voice-begin event with its sample position. It
// takes one event per clock cycle unless stalled: an event passes an input register, is
// judged by one compare-and-transition step against the phase state, and its report, if
// any, enters the result register. The 32-bit elapsed-slice counter of the current phase
// sets the depth of that step. The user must write limits on the configuration port while
// no event is in flight (unenforced); there is no clearing pass after reset.
`include "answer_machine_detector_fsm_defines.svh"

module answer_machine_detector_fsm (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [amd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [amd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  amd_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output amd_pkg::out_item_t                  out_data
);
    import amd_pkg::*;

    logic [CFG_DATA_W-1:0] dead_air_limit_reg;
    logic [CFG_DATA_W-1:0] machine_voice_limit_reg;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [31:0] elapsed_reg;
    logic [31:0] elapsed_next;
    logic [31:0] elapsed_inc;

    logic      advance;
    logic      proc;
    logic      silent;
    logic      emit;
    logic [2:0] emit_code;

    // The result register frees up when it is empty or its transfer happens now.
    assign advance  = !out_valid_reg || !out_stall;
    assign proc     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_air_limit_reg      <= DEAD_AIR_LIMIT_RESET;
            machine_voice_limit_reg <= MACHINE_VOICE_LIMIT_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_DEAD_AIR_LIMIT:      dead_air_limit_reg <= cfg_data;
                CFG_MACHINE_VOICE_LIMIT: machine_voice_limit_reg <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // The counter holds slices since the phase began; it restarts at zero on every
    // phase change, which matches the slice count minus the phase start modulo 2^32.
    assign elapsed_inc = elapsed_reg + 32'd1;

    always_comb
    begin
        silent     = in_item_reg.func inside {VAD_SILENCE_BEGIN, VAD_SILENCE};
        phase_next = phase_reg;
        emit       = 1'b0;
        emit_code  = EV_DEAD_AIR;
        case (phase_reg)
            PH_WAIT:
            begin
                if (silent)
                begin
                    if (elapsed_inc >= {16'd0, dead_air_limit_reg})
                    begin
                        phase_next = PH_DONE;
                        emit       = 1'b1;
                        emit_code  = EV_DEAD_AIR;
                    end
                end
                else
                begin
                    phase_next = PH_DETECT;
                end
            end
            PH_DETECT:
            begin
                if (silent)
                begin
                    phase_next = PH_HUMAN;
                    emit       = 1'b1;
                    emit_code  = EV_HUMAN_SILENCE;
                end
                else if (elapsed_inc >= {16'd0, machine_voice_limit_reg})
                begin
                    phase_next = PH_MACHINE;
                    emit       = 1'b1;
                    emit_code  = EV_MACHINE_VOICE;
                end
            end
            PH_HUMAN:
            begin
                case (in_item_reg.func)
                    VAD_SILENCE_BEGIN:
                    begin
                        emit      = 1'b1;
                        emit_code = EV_HUMAN_SILENCE;
                    end
                    VAD_VOICE_BEGIN:
                    begin
                        emit      = 1'b1;
                        emit_code = EV_HUMAN_VOICE;
                    end
                    default: ;
                endcase
            end
            PH_MACHINE:
            begin
                case (in_item_reg.func)
                    VAD_SILENCE_BEGIN:
                    begin
                        emit      = 1'b1;
                        emit_code = EV_MACHINE_SILENCE;
                    end
                    VAD_VOICE_BEGIN:
                    begin
                        emit      = 1'b1;
                        emit_code = EV_MACHINE_VOICE;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        elapsed_next = (phase_next != phase_reg) ? 32'd0 : elapsed_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_WAIT;
            elapsed_reg   <= 32'd0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= proc && emit;
            end
            if (proc)
            begin
                phase_reg   <= phase_next;
                elapsed_reg <= elapsed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_data;
        end
        if (proc && emit)
        begin
            out_item_reg.detect_event <= emit_code;
            out_item_reg.event_sample <= in_item_reg.sample_position;
        end
    end

    `AMD_ASSERT_NEXT(a_done_is_final, clk, rst_n, phase_reg == PH_DONE, phase_reg == PH_DONE)
    `AMD_ASSERT_NEXT(a_verdict_reports, clk, rst_n,
        proc && phase_reg == PH_DETECT && phase_next != PH_DETECT, out_valid_reg)
    `AMD_ASSERT_NEXT(a_phase_restarts_count, clk, rst_n,
        proc && phase_next != phase_reg, elapsed_reg == 32'd0)
    `AMD_ASSERT(a_result_from_event, clk, rst_n, $rose(out_valid_reg) |-> $past(proc))

endmodule
